FILE: src/xor_key_plaintext_checker_macros.svh
// Assertion macros for the repeating-key XOR checker.
// No dependencies; included by the top level only.
`ifndef XOR_KEY_PLAINTEXT_CHECKER_MACROS_SVH
`define XOR_KEY_PLAINTEXT_CHECKER_MACROS_SVH

// Same-cycle implication, held off during reset
`define XKPC_ASSERT_NOW(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("xkpc: same-cycle check failed");

// Next-cycle implication, held off during reset
`define XKPC_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("xkpc: next-cycle check failed");

`endif

FILE: src/xkpc_pkg.sv
// Shared types, constants and helpers for the repeating-key XOR checker.
// No dependencies.
`default_nettype none

package xkpc_pkg;

    localparam int KEY_W    = 40;
    localparam int POS_W    = 3;
    localparam int CNT_W    = 13;
    localparam int CNT_SAT  = 8191;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;

    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [7:0]  CHAR_NUL   = 8'h00;
    localparam logic [31:0] WORD_HOGY  = 32'h686F6779;
    localparam logic [23:0] WORD_NEM   = 24'h6E656D;
    localparam logic [15:0] WORD_AZ    = 16'h617A;
    localparam logic [15:0] WORD_HA    = 16'h6861;

    // One classified byte passed from front to back
    typedef struct packed {
        logic [7:0] plain;
        logic [7:0] lowered;
        logic       is_space;
        logic       is_zero;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } q_status_t;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/xkpc_front.sv
// Front end: key stepping, XOR and byte classification.
// Depends on xkpc_pkg.
`default_nettype none

module xkpc_front
    import xkpc_pkg::*;
#(
    parameter int KEY_LEN = 5
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [KEY_W-1:0] key_bytes,
    input  wire logic             take,
    input  wire logic [7:0]       cipher_byte,
    input  wire logic             last,
    output item_t                 item
);

    logic [POS_W-1:0] key_pos_reg;
    logic [POS_W-1:0] key_pos_next;
    logic [POS_W:0]   pos_inc;
    logic [63:0]      key_ext;
    logic [63:0]      key_shift;
    logic [7:0]       plain;

    // bytes beyond the 40-bit key read as zero
    assign key_ext   = {{(64-KEY_W){1'b0}}, key_bytes};
    assign key_shift = key_ext >> {key_pos_reg, 3'b000};
    assign plain     = cipher_byte ^ key_shift[7:0];
    assign pos_inc   = {1'b0, key_pos_reg} + {{POS_W{1'b0}}, 1'b1};

    always_comb
    begin
        item.plain    = plain;
        item.lowered  = lower_ascii(plain);
        item.is_space = (plain == CHAR_SPACE);
        item.is_zero  = (plain == CHAR_NUL);
        item.last     = last;
    end

    always_comb
    begin
        key_pos_next = key_pos_reg;
        if (take)
        begin
            if (last || pos_inc >= (POS_W+1)'(KEY_LEN))
            begin
                key_pos_next = '0;
            end
            else
            begin
                key_pos_next = pos_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_pos_reg <= '0;
        end
        else
        begin
            key_pos_reg <= key_pos_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/xkpc_queue.sv
// Two-entry queue decoupling the front end from the back end.
// Depends on xkpc_pkg.
`default_nettype none

module xkpc_queue
    import xkpc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire item_t wr_item,
    input  wire logic  rd_en,
    output item_t      rd_item,
    output q_status_t  status
);

    item_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign rd_item      = slot_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/xkpc_back.sv
// Back end: byte/space counters, word search, verdict and result register.
// Depends on xkpc_pkg.
`default_nettype none

module xkpc_back
    import xkpc_pkg::*;
#(
    parameter int KEEP_LIMIT = 4096
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_empty,
    input  wire item_t q_item,
    output logic       take,
    input  wire logic  pop,
    output logic       empty,
    output logic [7:0] plain_byte,
    output logic       verdict_valid,
    output logic       plausible
);

    logic [CNT_W-1:0] byte_count_reg;
    logic [CNT_W-1:0] byte_count_next;
    logic [CNT_W-1:0] space_count_reg;
    logic [CNT_W-1:0] space_count_next;
    logic [23:0]      recent_reg;
    logic [23:0]      recent_next;
    logic [3:0]       words_reg;
    logic [3:0]       words_next;
    logic             text_ended_reg;
    logic             text_ended_next;
    logic             out_valid_reg;
    logic [7:0]       plain_reg;
    logic             verdict_reg;
    logic             plausible_reg;
    logic [31:0]      window;
    logic [15:0]      space_x6;
    logic [16:0]      space_x9;
    logic             verdict_ok;

    assign take          = !q_empty && (!out_valid_reg || pop);
    assign empty         = !out_valid_reg;
    assign plain_byte    = plain_reg;
    assign verdict_valid = verdict_reg;
    assign plausible     = plausible_reg;

    assign window = {recent_reg, q_item.lowered};

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        space_count_next = space_count_reg;
        recent_next      = recent_reg;
        words_next       = words_reg;
        text_ended_next  = text_ended_reg;
        if (byte_count_reg < CNT_W'(KEEP_LIMIT))
        begin
            byte_count_next = byte_count_reg + 1'b1;
            if (q_item.is_space)
            begin
                space_count_next = space_count_reg + 1'b1;
            end
            if (!text_ended_reg)
            begin
                if (q_item.is_zero)
                begin
                    text_ended_next = 1'b1;
                end
                else
                begin
                    if (window == WORD_HOGY)
                    begin
                        words_next[0] = 1'b1;
                    end
                    if (window[23:0] == WORD_NEM)
                    begin
                        words_next[1] = 1'b1;
                    end
                    if (window[15:0] == WORD_AZ)
                    begin
                        words_next[2] = 1'b1;
                    end
                    if (window[15:0] == WORD_HA)
                    begin
                        words_next[3] = 1'b1;
                    end
                    recent_next = window[23:0];
                end
            end
        end
    end

    // verdict uses the counts including the current byte
    assign space_x6 = {1'b0, space_count_next, 2'b00} + {2'b00, space_count_next, 1'b0};
    assign space_x9 = {1'b0, space_count_next, 3'b000} + {4'b0000, space_count_next};
    assign verdict_ok = (space_count_next != '0)
                        && (space_x6 < {3'b000, byte_count_next})
                        && (space_x9 > {4'b0000, byte_count_next})
                        && (words_next == 4'hF);

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            plain_reg     <= q_item.plain;
            verdict_reg   <= q_item.last;
            plausible_reg <= q_item.last && verdict_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            byte_count_reg  <= '0;
            space_count_reg <= '0;
            recent_reg      <= '0;
            words_reg       <= '0;
            text_ended_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (take)
            begin
                if (q_item.last)
                begin
                    byte_count_reg  <= '0;
                    space_count_reg <= '0;
                    recent_reg      <= '0;
                    words_reg       <= '0;
                    text_ended_reg  <= 1'b0;
                end
                else
                begin
                    byte_count_reg  <= byte_count_next;
                    space_count_reg <= space_count_next;
                    recent_reg      <= recent_next;
                    words_reg       <= words_next;
                    text_ended_reg  <= text_ended_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/xor_key_plaintext_checker.sv
// Top level of the repeating-key XOR decryptor with plaintext test.
// Depends on xkpc_pkg, xkpc_front, xkpc_queue, xkpc_back and the macros header.
//
// Usage:
//   Input queue side: drive cipher_byte and last, raise push; a byte is taken
//   at a clock edge with push high and full low. last marks the message end.
//   Result queue side: while empty is low, plain_byte, verdict_valid and
//   plausible show the oldest result; pop high takes it at the clock edge.
//   Key: key_we high writes key_bytes (byte 0 in the low bits); write only
//   while no request is in flight.
//   Path: a pushed byte passes the combinational front XOR into a two-entry
//   queue, the back end moves it into the result register, and from there it
//   shows on the result ports. Throughput: one byte per cycle while results are
//   popped, limited by the single result register and the back-end counter update.
//   If pop is held low, up to two further bytes fill the queue, then full
//   rises; no byte is dropped.
//   Reset clears the key, the key position, the counters, the queue and the
//   result valid flag. After each message's last byte the message state
//   returns to reset.
`default_nettype none
`include "xor_key_plaintext_checker_macros.svh"

module xor_key_plaintext_checker
    import xkpc_pkg::*;
#(
    parameter int KEY_LEN = 5,
    parameter int MAX_LEN = 4096
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [7:0]       cipher_byte,
    input  wire logic             last,
    output logic                  empty,
    input  wire logic             pop,
    output logic [7:0]            plain_byte,
    output logic                  verdict_valid,
    output logic                  plausible,
    input  wire logic             key_we,
    input  wire logic [KEY_W-1:0] key_bytes
);

    localparam int KEEP_LIMIT = (MAX_LEN < CNT_SAT) ? MAX_LEN : CNT_SAT;

    logic [KEY_W-1:0] key_bytes_reg;
    logic             push_ok;
    logic             back_take;
    item_t            front_item;
    item_t            q_item;
    q_status_t        q_status;

    assign full    = q_status.full;
    assign push_ok = push && !q_status.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg <= '0;
        end
        else if (key_we)
        begin
            key_bytes_reg <= key_bytes;
        end
    end

    xkpc_front #(
        .KEY_LEN (KEY_LEN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_bytes   (key_bytes_reg),
        .take        (push_ok),
        .cipher_byte (cipher_byte),
        .last        (last),
        .item        (front_item)
    );

    xkpc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push_ok),
        .wr_item (front_item),
        .rd_en   (back_take),
        .rd_item (q_item),
        .status  (q_status)
    );

    xkpc_back #(
        .KEEP_LIMIT (KEEP_LIMIT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_status.empty),
        .q_item        (q_item),
        .take          (back_take),
        .pop           (pop),
        .empty         (empty),
        .plain_byte    (plain_byte),
        .verdict_valid (verdict_valid),
        .plausible     (plausible)
    );

    // a verdict bit only ever rides on the message's last result
    `XKPC_ASSERT_NOW(a_plausible_on_last, clk, rst_n, !empty && plausible, verdict_valid)
    // the back end never reads an empty queue
    `XKPC_ASSERT_NOW(a_no_underflow, clk, rst_n, back_take, !q_status.empty)
    // a lone push grows the queue by one entry
    `XKPC_ASSERT_NEXT(a_push_grows, clk, rst_n, push_ok && !back_take,
        q_status.count == $past(q_status.count) + 2'd1)
    // a result taken by the back end always leaves a result waiting
    `XKPC_ASSERT_NEXT(a_take_fills, clk, rst_n, back_take, !empty)

endmodule

`default_nettype wire
